@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

    // Field widths
    localparam int RAW_W  = 24;
    localparam int Q_FRAC = 24;
    localparam int PS_W   = 32;
    localparam int OSR_N  = 8;
    localparam int OSR_W  = 3;
    localparam int REC_W  = 32;
    localparam int PRES_W = 32;
    localparam int TEMP_W = 24;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 3;

    // Oversampling scale factors
    localparam logic [63:0] OSR_K0 = 64'd524288;
    localparam logic [63:0] OSR_K1 = 64'd1572864;
    localparam logic [63:0] OSR_K2 = 64'd3670016;
    localparam logic [63:0] OSR_K3 = 64'd7864320;
    localparam logic [63:0] OSR_K4 = 64'd253952;
    localparam logic [63:0] OSR_K5 = 64'd516096;
    localparam logic [63:0] OSR_K6 = 64'd1040384;
    localparam logic [63:0] OSR_K7 = 64'd2088960;
    localparam logic [63:0] ONE48  = 64'd1 << 48;

    // Rounded reciprocals round(2^48 / k)
    localparam logic [63:0] REC0 = (ONE48 + OSR_K0 / 2) / OSR_K0;
    localparam logic [63:0] REC1 = (ONE48 + OSR_K1 / 2) / OSR_K1;
    localparam logic [63:0] REC2 = (ONE48 + OSR_K2 / 2) / OSR_K2;
    localparam logic [63:0] REC3 = (ONE48 + OSR_K3 / 2) / OSR_K3;
    localparam logic [63:0] REC4 = (ONE48 + OSR_K4 / 2) / OSR_K4;
    localparam logic [63:0] REC5 = (ONE48 + OSR_K5 / 2) / OSR_K5;
    localparam logic [63:0] REC6 = (ONE48 + OSR_K6 / 2) / OSR_K6;
    localparam logic [63:0] REC7 = (ONE48 + OSR_K7 / 2) / OSR_K7;

    localparam logic [REC_W-1:0] RECIP [OSR_N] = '{
        REC0[REC_W-1:0], REC1[REC_W-1:0], REC2[REC_W-1:0], REC3[REC_W-1:0],
        REC4[REC_W-1:0], REC5[REC_W-1:0], REC6[REC_W-1:0], REC7[REC_W-1:0]
    };

    localparam logic [OSR_W-1:0] OSR_RESET = 3'd6;

    // Register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_CALIB_LOW  = 3'd0,
        REG_CALIB_MID  = 3'd1,
        REG_CALIB_HIGH = 3'd2,
        REG_P_OSR      = 3'd3,
        REG_T_OSR      = 3'd4
    } t_reg_idx;

    // Unpacked calibration set
    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
        logic [OSR_W-1:0]   p_osr;
        logic [OSR_W-1:0]   t_osr;
    } t_coef;

endpackage

@@ rtl/bpc_scale.sv @@
module bpc_scale
    import bpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [RAW_W-1:0]       i_raw_p,
    input  logic [RAW_W-1:0]       i_raw_t,
    input  logic [OSR_W-1:0]       i_p_osr,
    input  logic [OSR_W-1:0]       i_t_osr,
    output logic                   o_vld,
    output logic signed [PS_W-1:0] o_ps,
    output logic signed [PS_W-1:0] o_ts
);

    localparam int PROD_W = RAW_W + REC_W + 1;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (Q_FRAC - 1));

    logic [1:0]               r_vld;
    logic signed [PROD_W-1:0] r_prod_p;
    logic signed [PROD_W-1:0] r_prod_t;
    logic signed [PROD_W-1:0] n_prod_p;
    logic signed [PROD_W-1:0] n_prod_t;
    logic signed [PROD_W-1:0] n_rnd_p;
    logic signed [PROD_W-1:0] n_rnd_t;
    logic signed [PS_W-1:0]   r_ps;
    logic signed [PS_W-1:0]   r_ts;

    // Multiply each reading by its reciprocal
    always_comb begin
        n_prod_p = $signed(i_raw_p) * $signed({1'b0, RECIP[i_p_osr]});
        n_prod_t = $signed(i_raw_t) * $signed({1'b0, RECIP[i_t_osr]});
        n_rnd_p  = (r_prod_p + HALF) >>> Q_FRAC;
        n_rnd_t  = (r_prod_t + HALF) >>> Q_FRAC;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_p <= n_prod_p;
            r_prod_t <= n_prod_t;
            r_ps     <= n_rnd_p[PS_W-1:0];
            r_ts     <= n_rnd_t[PS_W-1:0];
        end
    end

    assign o_vld = r_vld[1];
    assign o_ps  = r_ps;
    assign o_ts  = r_ts;

endmodule

@@ rtl/bpc_poly.sv @@
module bpc_poly
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [PS_W-1:0]   i_ps,
    input  logic signed [PS_W-1:0]   i_ts,
    input  t_coef                    i_coef,
    output logic                     o_vld,
    output logic signed [PRES_W-1:0] o_pressure,
    output logic signed [TEMP_W-1:0] o_temperature
);

    localparam int A_W  = 48;
    localparam int B_W  = 52;
    localparam int T_W  = 29;
    localparam int PL_W = PS_W + Q_FRAC + 1;
    localparam int PH_W = PS_W + B_W - Q_FRAC;
    localparam int P_W  = 60;
    localparam logic signed [PL_W-1:0] HALF_Q = PL_W'(64'd1 << (Q_FRAC - 1));
    localparam logic signed [43:0]     HALF_T = 44'sd32768;
    localparam logic signed [P_W-1:0]  HALF_P = P_W'(64'd1 << 17);
    localparam logic signed [T_W-1:0]  T_MAX  = T_W'(64'd8388607);
    localparam logic signed [T_W-1:0]  T_MIN  = -T_W'(64'd8388608);
    localparam logic signed [P_W-1:0]  P_MAX  = P_W'(64'd2147483647);
    localparam logic signed [P_W-1:0]  P_MIN  = -P_W'(64'd2147483648);

    logic [6:0] r_vld;

    // Stage 3: first products
    logic signed [47:0]     r_s3_c30ps, r_s3_c21ps, r_s3_c01ts;
    logic signed [43:0]     r_s3_c1ts;
    logic signed [PS_W-1:0] r_s3_ps, r_s3_ts;
    // Stage 4: inner sums, temperature
    logic signed [A_W-1:0]    r_s4_a, r_s4_d;
    logic signed [47:0]       r_s4_c01ts;
    logic signed [TEMP_W-1:0] r_s4_t;
    logic signed [PS_W-1:0]   r_s4_ps, r_s4_ts;
    logic signed [A_W-1:0]    n_a, n_d;
    logic signed [43:0]       n_c1r;
    logic signed [T_W-1:0]    n_t;
    // Stage 5: split products
    logic signed [55:0]       r_s5_pah, r_s5_pdh;
    logic signed [PL_W-1:0]   r_s5_pal, r_s5_pdl;
    logic signed [47:0]       r_s5_c01ts;
    logic signed [TEMP_W-1:0] r_s5_t;
    logic signed [PS_W-1:0]   r_s5_ps, r_s5_ts;
    // Stage 6: b and e
    logic signed [B_W-1:0]    r_s6_b, r_s6_e;
    logic signed [47:0]       r_s6_c01ts;
    logic signed [TEMP_W-1:0] r_s6_t;
    logic signed [PS_W-1:0]   r_s6_ps, r_s6_ts;
    logic signed [PL_W-1:0]   n_ral, n_rdl;
    logic signed [P_W-1:0]    n_b, n_e;
    // Stage 7: split products
    logic signed [PH_W-1:0]   r_s7_pbh, r_s7_teh;
    logic signed [PL_W-1:0]   r_s7_pbl, r_s7_tel;
    logic signed [47:0]       r_s7_c01ts;
    logic signed [TEMP_W-1:0] r_s7_t;
    // Stage 8: outer products rounded
    logic signed [P_W-1:0]    r_s8_mb, r_s8_me;
    logic signed [47:0]       r_s8_c01ts;
    logic signed [TEMP_W-1:0] r_s8_t;
    logic signed [PL_W-1:0]   n_rbl, n_rel;
    // Stage 9: output
    logic signed [P_W-1:0]    n_p, n_pr;
    logic signed [PRES_W-1:0] r_pres;
    logic signed [TEMP_W-1:0] r_temp;

    always_comb begin
        // Inner sums and temperature
        n_a   = (A_W'(i_coef.c20) <<< Q_FRAC) + A_W'(r_s3_c30ps);
        n_d   = (A_W'(i_coef.c11) <<< Q_FRAC) + A_W'(r_s3_c21ps);
        n_c1r = (r_s3_c1ts + HALF_T) >>> 16;
        n_t   = (T_W'(i_coef.c0) <<< 7) + T_W'(n_c1r);
        // Rounded lower terms of ps*a and ps*d
        n_ral = (r_s5_pal + HALF_Q) >>> Q_FRAC;
        n_rdl = (r_s5_pdl + HALF_Q) >>> Q_FRAC;
        n_b   = (P_W'(i_coef.c10) <<< Q_FRAC) + P_W'(r_s5_pah) + P_W'(n_ral);
        n_e   = P_W'(r_s5_pdh) + P_W'(n_rdl);
        // Rounded lower terms of ps*b and ts*e
        n_rbl = (r_s7_pbl + HALF_Q) >>> Q_FRAC;
        n_rel = (r_s7_tel + HALF_Q) >>> Q_FRAC;
        // Final pressure sum
        n_p   = (P_W'(i_coef.c00) <<< Q_FRAC) + r_s8_mb + r_s8_me + P_W'(r_s8_c01ts);
        n_pr  = (n_p + HALF_P) >>> 18;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_c30ps <= i_coef.c30 * i_ps;
            r_s3_c21ps <= i_coef.c21 * i_ps;
            r_s3_c01ts <= i_coef.c01 * i_ts;
            r_s3_c1ts  <= i_coef.c1 * i_ts;
            r_s3_ps    <= i_ps;
            r_s3_ts    <= i_ts;

            r_s4_a     <= n_a;
            r_s4_d     <= n_d;
            r_s4_c01ts <= r_s3_c01ts;
            if (n_t > T_MAX) begin
                r_s4_t <= T_MAX[TEMP_W-1:0];
            end else if (n_t < T_MIN) begin
                r_s4_t <= T_MIN[TEMP_W-1:0];
            end else begin
                r_s4_t <= n_t[TEMP_W-1:0];
            end
            r_s4_ps    <= r_s3_ps;
            r_s4_ts    <= r_s3_ts;

            r_s5_pah   <= r_s4_ps * $signed(r_s4_a[A_W-1:Q_FRAC]);
            r_s5_pal   <= r_s4_ps * $signed({1'b0, r_s4_a[Q_FRAC-1:0]});
            r_s5_pdh   <= r_s4_ps * $signed(r_s4_d[A_W-1:Q_FRAC]);
            r_s5_pdl   <= r_s4_ps * $signed({1'b0, r_s4_d[Q_FRAC-1:0]});
            r_s5_c01ts <= r_s4_c01ts;
            r_s5_t     <= r_s4_t;
            r_s5_ps    <= r_s4_ps;
            r_s5_ts    <= r_s4_ts;

            r_s6_b     <= n_b[B_W-1:0];
            r_s6_e     <= n_e[B_W-1:0];
            r_s6_c01ts <= r_s5_c01ts;
            r_s6_t     <= r_s5_t;
            r_s6_ps    <= r_s5_ps;
            r_s6_ts    <= r_s5_ts;

            r_s7_pbh   <= r_s6_ps * $signed(r_s6_b[B_W-1:Q_FRAC]);
            r_s7_pbl   <= r_s6_ps * $signed({1'b0, r_s6_b[Q_FRAC-1:0]});
            r_s7_teh   <= r_s6_ts * $signed(r_s6_e[B_W-1:Q_FRAC]);
            r_s7_tel   <= r_s6_ts * $signed({1'b0, r_s6_e[Q_FRAC-1:0]});
            r_s7_c01ts <= r_s6_c01ts;
            r_s7_t     <= r_s6_t;

            r_s8_mb    <= P_W'(r_s7_pbh) + P_W'(n_rbl);
            r_s8_me    <= P_W'(r_s7_teh) + P_W'(n_rel);
            r_s8_c01ts <= r_s7_c01ts;
            r_s8_t     <= r_s7_t;

            if (n_pr > P_MAX) begin
                r_pres <= P_MAX[PRES_W-1:0];
            end else if (n_pr < P_MIN) begin
                r_pres <= P_MIN[PRES_W-1:0];
            end else begin
                r_pres <= n_pr[PRES_W-1:0];
            end
            r_temp <= r_s8_t;
        end
    end

    assign o_vld         = r_vld[6];
    assign o_pressure    = r_pres;
    assign o_temperature = r_temp;

endmodule

@@ rtl/baro_pressure_temp_compensate_top.sv @@
// Channel   Dir  Handshake             Payload
// s (in)    in   i_s_tvalid/o_s_tready i_s_tdata: raw_pressure, raw_temperature
// m (out)   out  o_m_tvalid/i_m_tready o_m_tdata: pressure_out, temperature_out
// cfg       in   i_cfg_wen             i_cfg_addr, i_cfg_wdata
//
// One item per cycle while the output is not stalled.
// The depth comes from three chained 32x32-class multiply stages, each split
// into a product stage and a rounding/add stage, plus input scaling and output clamp.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
// Synchronous reset empties the pipeline and loads the default register values.
module baro_pressure_temp_compensate_top
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [47:0]       i_s_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [55:0]       o_m_tdata,  // [31:0] pressure_out, [55:32] temperature_out
    input  logic              i_cfg_wen,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    logic [CFG_W-1:0] r_calib_low;
    logic [CFG_W-1:0] r_calib_mid;
    logic [15:0]      r_calib_high;
    logic [OSR_W-1:0] r_p_osr;
    logic [OSR_W-1:0] r_t_osr;
    t_coef            coef;
    logic             en;
    logic             sc_vld;
    logic signed [PS_W-1:0]   sc_ps;
    logic signed [PS_W-1:0]   sc_ts;
    logic signed [PRES_W-1:0] pres;
    logic signed [TEMP_W-1:0] temp;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_low  <= '0;
            r_calib_mid  <= '0;
            r_calib_high <= '0;
            r_p_osr      <= OSR_RESET;
            r_t_osr      <= OSR_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                REG_CALIB_LOW:  r_calib_low  <= i_cfg_wdata;
                REG_CALIB_MID:  r_calib_mid  <= i_cfg_wdata;
                REG_CALIB_HIGH: r_calib_high <= i_cfg_wdata[15:0];
                REG_P_OSR:      r_p_osr      <= i_cfg_wdata[OSR_W-1:0];
                REG_T_OSR:      r_t_osr      <= i_cfg_wdata[OSR_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack calibration fields
    always_comb begin
        coef.c0    = $signed(r_calib_low[63:52]);
        coef.c1    = $signed(r_calib_low[51:40]);
        coef.c00   = $signed(r_calib_low[39:20]);
        coef.c10   = $signed(r_calib_low[19:0]);
        coef.c01   = $signed(r_calib_mid[63:48]);
        coef.c11   = $signed(r_calib_mid[47:32]);
        coef.c20   = $signed(r_calib_mid[31:16]);
        coef.c21   = $signed(r_calib_mid[15:0]);
        coef.c30   = $signed(r_calib_high);
        coef.p_osr = r_p_osr;
        coef.t_osr = r_t_osr;
    end

    // Advance the pipeline unless the output holds an untaken result
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    bpc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_raw_p (i_s_tdata[23:0]),
        .i_raw_t (i_s_tdata[47:24]),
        .i_p_osr (coef.p_osr),
        .i_t_osr (coef.t_osr),
        .o_vld   (sc_vld),
        .o_ps    (sc_ps),
        .o_ts    (sc_ts)
    );

    bpc_poly u_poly (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (sc_vld),
        .i_ps          (sc_ps),
        .i_ts          (sc_ts),
        .i_coef        (coef),
        .o_vld         (o_m_tvalid),
        .o_pressure    (pres),
        .o_temperature (temp)
    );

    assign o_m_tdata = {temp, pres};

    // Input is refused only while a result waits on a stalled output
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input refused without output stall");

    // Reset loads default oversampling indexes
    a_osr_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_p_osr == OSR_RESET && r_t_osr == OSR_RESET))
        else $error("oversampling index not reset");

    // A pressure index write lands in its register
    a_osr_write: assert property (@(posedge i_clk)
        (i_rst_n && i_cfg_wen && i_cfg_addr == REG_P_OSR)
        |=> r_p_osr == $past(i_cfg_wdata[OSR_W-1:0]))
        else $error("pressure index write lost");

endmodule

@@ tb/tb_baro_pressure_temp_compensate_top.sv @@
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensate_top;
    import bpc_pkg::*;

    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 14;

    // temperature in the upper bits, pressure in the lower bits, as on o_m_tdata
    typedef struct packed {
        logic signed [23:0] temperature;
        logic signed [31:0] pressure;
    } t_reading;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [55:0]       o_m_tdata;
    logic              i_cfg_wen = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    // shadow copy of the calibration and oversampling registers
    logic [63:0] cal_low, cal_mid;
    logic [15:0] cal_high;
    logic [2:0]  p_osr, t_osr;

    t_reading    expected_q[$];
    int          err_count = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_cfg = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          rx_hold = 0;

    baro_pressure_temp_compensate_top dut (.*);

    always #10 i_clk = ~i_clk;

    // pick calibration byte k (0..17)
    function automatic logic [7:0] cal_byte(int k);
        if (k < 8) return cal_low[63 - 8*k -: 8];
        if (k < 16) return cal_mid[63 - 8*(k-8) -: 8];
        if (k == 16) return cal_high[15:8];
        return cal_high[7:0];
    endfunction

    function automatic longint pair16(int k);
        logic signed [15:0] v;
        v = {cal_byte(k), cal_byte(k+1)};
        return longint'(v);
    endfunction

    function automatic longint osr_factor(logic [2:0] idx);
        case (idx)
            3'd0: return 524288;
            3'd1: return 1572864;
            3'd2: return 3670016;
            3'd3: return 7864320;
            3'd4: return 253952;
            3'd5: return 516096;
            3'd6: return 1040384;
            default: return 2088960;
        endcase
    endfunction

    // raw / k in Q.24 via a rounded 2^48 reciprocal
    function automatic longint to_q24(logic [23:0] raw, logic [2:0] idx);
        longint k, r, x;
        logic signed [23:0] sr;
        k = osr_factor(idx);
        r = ((64'sd1 <<< 48) + (k >>> 1)) / k;
        sr = raw;
        x = longint'(sr);
        return (x * r + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // round(x * y / 2^24), split to keep the products in range
    function automatic longint qmul(longint x, longint y);
        longint yh, yl;
        yh = y >>> 24;
        yl = y & 64'hFF_FFFF;
        return x * yh + ((x * yl + (64'sd1 <<< 23)) >>> 24);
    endfunction

    function automatic t_reading compensate(logic [23:0] raw_p, logic [23:0] raw_t);
        logic signed [11:0] c0_v, c1_v;
        logic signed [19:0] c00_v, c10_v;
        logic [7:0] b1, b5;
        longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint ps, ts, a, b, d, e, p, t, one;
        t_reading res;
        b1 = cal_byte(1);
        b5 = cal_byte(5);
        c0_v  = {cal_byte(0), b1[7:4]};
        c1_v  = {b1[3:0], cal_byte(2)};
        c00_v = {cal_byte(3), cal_byte(4), b5[7:4]};
        c10_v = {b5[3:0], cal_byte(6), cal_byte(7)};
        c0 = longint'(c0_v);
        c1 = longint'(c1_v);
        c00 = longint'(c00_v);
        c10 = longint'(c10_v);
        c01 = pair16(8);
        c11 = pair16(10);
        c20 = pair16(12);
        c21 = pair16(14);
        c30 = pair16(16);
        ps = to_q24(raw_p, p_osr);
        ts = to_q24(raw_t, t_osr);
        one = 64'sd1 <<< 24;
        t = c0 * 128 + ((c1 * ts + (64'sd1 <<< 15)) >>> 16);
        if (t < -64'sd8388608) t = -64'sd8388608;
        if (t > 64'sd8388607) t = 64'sd8388607;
        a = c20 * one + c30 * ps;
        b = c10 * one + qmul(ps, a);
        d = c11 * one + c21 * ps;
        e = qmul(ps, d);
        p = c00 * one + qmul(ps, b) + c01 * ts + qmul(ts, e);
        p = (p + (64'sd1 <<< 17)) >>> 18;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        res.pressure = p[31:0];
        res.temperature = t[23:0];
        return res;
    endfunction

    // predict on every input transfer, check every output transfer
    always @(posedge i_clk) begin
        t_reading got, want;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            expected_q.push_back(compensate(i_s_tdata[23:0], i_s_tdata[47:24]));
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected result p=%0d t=%0d",
                             got.pressure, got.temperature);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (got.pressure !== want.pressure ||
                    got.temperature !== want.temperature) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: result %0d exp p=%0d t=%0d got p=%0d t=%0d",
                                 n_checked, want.pressure, want.temperature,
                                 got.pressure, got.temperature);
                end
            end
        end
    end

    // receiver: random stalls, optional long hold-off
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one reading pair, return at the falling edge after its transfer
    task automatic send_reading(logic [23:0] raw_p, logic [23:0] raw_t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata <= {raw_t, raw_p};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
        @(negedge i_clk);
    endtask

    // stop sending and wait until every result is in, plus pipeline depth
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [63:0] value);
        i_cfg_wen <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        n_cfg++;
        case (addr)
            REG_CALIB_LOW:  cal_low = value;
            REG_CALIB_MID:  cal_mid = value;
            REG_CALIB_HIGH: cal_high = value[15:0];
            REG_P_OSR:      p_osr = value[2:0];
            REG_T_OSR:      t_osr = value[2:0];
            default: ;
        endcase
    endtask

    task automatic load_calib(logic [63:0] lo, logic [63:0] mid, logic [15:0] hi,
                              logic [2:0] po, logic [2:0] to);
        drain();
        write_reg(REG_CALIB_LOW, lo);
        write_reg(REG_CALIB_MID, mid);
        write_reg(REG_CALIB_HIGH, {48'hFFFF_FFFF_FFFF, hi});
        write_reg(REG_P_OSR, {$urandom, 29'($urandom), po});
        write_reg(REG_T_OSR, {$urandom, 29'($urandom), to});
    endtask

    task automatic load_random_calib();
        load_calib({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    // extreme raw values against reset and extreme calibrations
    task automatic test_directed();
        logic [23:0] edges[5] = '{24'h000000, 24'h000001, 24'h7FFFFF,
                                  24'h800000, 24'hFFFFFF};
        // reset calibration gives zero outputs
        send_reading(24'h7FFFFF, 24'h800000);
        send_reading(24'h123456, 24'hFEDCBA);
        // unused register index must not disturb anything
        drain();
        write_reg(REG_UNUSED, '1);
        // all-ones and max-magnitude calibrations with the smallest and largest factors
        load_calib('1, '1, '1, 3'd4, 3'd4);
        foreach (edges[i]) send_reading(edges[i], edges[4 - i]);
        load_calib(64'h7FF8_007F_FFFF_FF7F, 64'hFF7F_FF7F_FF7F_FF7F, 16'h7FFF, 3'd4, 3'd3);
        foreach (edges[i]) send_reading(edges[i], edges[i]);
        load_calib(64'h8008_0080_0000_0080, 64'h8000_8000_8000_8000, 16'h8000, 3'd3, 3'd4);
        foreach (edges[i]) send_reading(edges[i], edges[(i + 2) % 5]);
    endtask

    // every oversampling index on both channels
    task automatic test_osr_sweep();
        for (int idx = 0; idx < 8; idx++) begin
            load_calib({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                       3'(idx), 3'(7 - idx));
            repeat (4) send_reading(24'($urandom), 24'($urandom));
        end
    endtask

    // hold the receiver off so the pipeline fills and stalls the input
    task automatic test_backpressure();
        load_random_calib();
        quiet = 1'b1;
        rx_hold = 80;
        repeat (40) send_reading(24'($urandom), 24'($urandom));
        quiet = 1'b0;
        drain();
    endtask

    // random readings over changing calibrations, with quiet stretches
    task automatic test_random();
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 4)
                load_calib('0, '0, '0, 3'd0, 3'd7);
            else
                load_random_calib();
            quiet = (ph % 3 == 2);
            repeat (100) begin
                logic [23:0] rp, rt;
                rp = 24'($urandom);
                rt = 24'($urandom);
                // bias some readings toward the sign boundaries
                if ($urandom_range(0, 7) == 0) rp = {rp[23], {23{rp[23] ^ 1'b1}}};
                if ($urandom_range(0, 7) == 0) rt = {rt[23], {23{rt[23] ^ 1'b1}}};
                send_reading(rp, rt);
            end
            quiet = 1'b0;
        end
        drain();
    endtask

    initial begin
        cal_low = '0;
        cal_mid = '0;
        cal_high = '0;
        p_osr = OSR_RESET;
        t_osr = OSR_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_osr_sweep();
        test_backpressure();
        test_random();
        $display("Sent %0d reading pairs, checked %0d results, %0d register writes,",
                 n_sent, n_checked, n_cfg);
        $display("covering all oversampling indexes, extreme calibrations and stalls.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
